FILE: sv/dss_pkg.sv
// Shared types and constants for the discrete state-space step block.
// No dependencies; used by the top level, the MAC unit and the checker.
`timescale 1ns / 1ps

package dss_pkg;

  // Fixed field widths of the stream payload
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 32;
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 64;

  // Sample sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  // Control that travels with each operand pair into the MAC
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

FILE: sv/discrete_state_space_step.sv
// Top level of the discrete state-space step: coefficient and state RAMs,
// sample sequencer and output register. Depends on dss_pkg, dss_ram, dss_mac.
//
// Channel   Dir  Signals                                   Moves
// s_*       in   s_tvalid s_tready s_tdata s_tuser         load word or input sample
// m_*       out  m_tvalid m_tready m_tdata                 output vector y
//
// A load transfer writes at most one word. A sample issues (NUM_OUTPUTS+NUM_STATES) *
// (NUM_STATES+NUM_INPUTS) products after its transfer and then drains the pipeline,
// all through the single shared multiply-accumulate, one product a cycle. Reset
// clears the state vector through valid bits; coefficients hold garbage until loaded.
// A sample transfer waits while a previous result is stalled. The next state goes to
// the other half of the state RAM, swapped at the end.
`timescale 1ns / 1ps

module discrete_state_space_step #(
  parameter int NUM_STATES  = 4,
  parameter int NUM_INPUTS  = 2,
  parameter int NUM_OUTPUTS = 2,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // coef_addr[5:0], coef_value[37:6], u0[69:38], u1[101:70], zero fill
  input  logic [dss_pkg::S_TDATA_W-1:0]   s_tdata,
  // func[0]
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // y0[31:0], y1[63:32]
  output logic [dss_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int OFS_A      = 0;
  localparam int OFS_B      = OFS_A + NUM_STATES * NUM_STATES;
  localparam int OFS_C      = OFS_B + NUM_STATES * NUM_INPUTS;
  localparam int OFS_D      = OFS_C + NUM_OUTPUTS * NUM_STATES;
  localparam int COEF_WORDS = OFS_D + NUM_OUTPUTS * NUM_INPUTS;
  localparam int ADDR_END   = COEF_WORDS + NUM_STATES;
  localparam int ROWS       = NUM_OUTPUTS + NUM_STATES;
  localparam int TERMS      = NUM_STATES + NUM_INPUTS;
  localparam int CAW        = $clog2(COEF_WORDS);
  localparam int SDEPTH     = 2 * NUM_STATES;
  localparam int SAW        = $clog2(SDEPTH);
  localparam int IW         = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int RW         = $clog2(ROWS);
  localparam int KW         = $clog2(TERMS);
  localparam int DW         = dss_pkg::DATA_W;

  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [RW-1:0] LAST_OUT = RW'(NUM_OUTPUTS - 1);
  localparam logic [RW-1:0] NO_ROW   = RW'(NUM_OUTPUTS);
  localparam logic [KW-1:0] LAST_K   = KW'(TERMS - 1);
  localparam logic [KW-1:0] NS_K     = KW'(NUM_STATES);

  // Payload fields
  logic                    func;
  logic [dss_pkg::ADDR_W-1:0] coef_addr;
  logic signed [DW-1:0]    coef_value;
  logic signed [DW-1:0]    u0_in;
  logic signed [DW-1:0]    u1_in;

  assign func       = s_tuser[0];
  assign coef_addr  = s_tdata[5:0];
  assign coef_value = signed'(s_tdata[37:6]);
  assign u0_in      = signed'(s_tdata[69:38]);
  assign u1_in      = signed'(s_tdata[101:70]);

  // Sequencer
  dss_pkg::seq_state_t state, state_next;
  logic            load_xfer;
  logic            sample_xfer;
  logic            issue;
  logic            issue_last;
  logic [RW-1:0]   row;
  logic [KW-1:0]   k;
  logic [KW-1:0]   uk;
  logic [CAW-1:0]  ptr_x;
  logic [CAW-1:0]  ptr_u;
  logic            bank;
  logic signed [DW-1:0] u0;
  logic signed [DW-1:0] u1;

  // Memory ports
  logic            coef_we;
  logic [CAW-1:0]  coef_waddr;
  logic [CAW-1:0]  coef_raddr;
  logic [DW-1:0]   coef_rdata;
  logic            sv_load;
  logic            sv_we;
  logic [IW-1:0]   sv_widx;
  logic            sv_wbank;
  logic [SAW-1:0]  sv_waddr;
  logic [DW-1:0]   sv_wdata;
  logic [SAW-1:0]  sv_raddr;
  logic [DW-1:0]   sv_rdata;
  logic [SDEPTH-1:0] sv_valid;

  // Operand stage and row tags
  dss_pkg::mac_tag_t     tag0;
  dss_pkg::mac_tag_t     tag1;
  logic                  is_u1;
  logic signed [DW-1:0]  op_u1;
  logic                  sv_vld1;
  logic [RW-1:0]         row1;
  logic [RW-1:0]         row2;
  logic [RW-1:0]         row3;
  logic signed [DW-1:0]  mac_b;
  logic                  mac_done;
  logic signed [DW-1:0]  mac_res;

  // Output register
  logic signed [DW-1:0]  y0;
  logic signed [DW-1:0]  y1;

  assign load_xfer   = s_tvalid && s_tready && !func;
  assign sample_xfer = s_tvalid && s_tready && func;
  assign issue_last  = (row == LAST_ROW) && (k == LAST_K);
  assign uk          = k - NS_K;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dss_pkg::ST_IDLE:  if (sample_xfer) state_next = dss_pkg::ST_RUN;
      dss_pkg::ST_RUN:   if (issue_last) state_next = dss_pkg::ST_DRAIN;
      dss_pkg::ST_DRAIN: if (mac_done && row3 == LAST_ROW) state_next = dss_pkg::ST_IDLE;
      default:           state_next = dss_pkg::ST_IDLE;
    endcase
  end

  // Handshake and issue control
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    unique case (state)
      dss_pkg::ST_IDLE:  s_tready = !func || !m_tvalid || m_tready;
      dss_pkg::ST_RUN:   issue = 1'b1;
      dss_pkg::ST_DRAIN: ;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk rows (outputs first, then next state) and terms of each row
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      row   <= '0;
      k     <= '0;
      ptr_x <= CAW'(OFS_C);
      ptr_u <= CAW'(OFS_D);
      u0    <= u0_in;
      u1    <= u1_in;
    end else if (issue) begin
      if (k < NS_K) begin
        ptr_x <= ptr_x + 1'b1;
      end else begin
        ptr_u <= ptr_u + 1'b1;
      end
      if (k == LAST_K) begin
        k   <= '0;
        row <= row + 1'b1;
        if (row == LAST_OUT) begin
          ptr_x <= CAW'(OFS_A);
          ptr_u <= CAW'(OFS_B);
        end
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  // Read addresses for the current term
  assign coef_raddr = (k < NS_K) ? ptr_x : ptr_u;
  assign sv_raddr   = bank ? SAW'(NUM_STATES) + SAW'(k[IW-1:0]) : SAW'(k[IW-1:0]);

  assign tag0.valid = issue;
  assign tag0.first = (k == '0);
  assign tag0.last  = (k == LAST_K);

  // Operand stage: aligned with the registered RAM reads
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag0;
    end
    is_u1   <= !(k < NS_K);
    sv_vld1 <= sv_valid[sv_raddr];
    row1    <= row;
    row2    <= row1;
    row3    <= row2;
    if (uk == KW'(0)) begin
      op_u1 <= u0;
    end else if (uk == KW'(1)) begin
      op_u1 <= u1;
    end else begin
      op_u1 <= '0;
    end
  end

  // State entries not written since reset read as zero
  assign mac_b = is_u1 ? op_u1 : (sv_vld1 ? signed'(sv_rdata) : '0);

  dss_mac #(
    .FRAC_BITS (FRAC_BITS),
    .TERMS     (TERMS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .tag    (tag1),
    .a      (signed'(coef_rdata)),
    .b      (mac_b),
    .done   (mac_done),
    .result (mac_res)
  );

  // Coefficient loads
  assign coef_we    = load_xfer && (32'(coef_addr) < COEF_WORDS);
  assign coef_waddr = CAW'(coef_addr);

  dss_ram #(
    .WIDTH (DW),
    .DEPTH (COEF_WORDS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // State writes: loads into the live half, next state into the other half
  assign sv_load  = load_xfer && (32'(coef_addr) >= COEF_WORDS) &&
                    (32'(coef_addr) < ADDR_END);
  assign sv_we    = sv_load || (mac_done && row3 >= NO_ROW);
  assign sv_widx  = sv_load ? IW'(32'(coef_addr) - COEF_WORDS) : IW'(row3 - NO_ROW);
  assign sv_wbank = sv_load ? bank : !bank;
  assign sv_waddr = sv_wbank ? SAW'(NUM_STATES) + SAW'(sv_widx) : SAW'(sv_widx);
  assign sv_wdata = sv_load ? coef_value : mac_res;

  dss_ram #(
    .WIDTH (DW),
    .DEPTH (SDEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (sv_we),
    .waddr (sv_waddr),
    .wdata (sv_wdata),
    .raddr (sv_raddr),
    .rdata (sv_rdata)
  );

  // Valid bits and half swap at the end of a sample
  always_ff @(posedge clk) begin
    if (rst) begin
      sv_valid <= '0;
      bank     <= 1'b0;
    end else begin
      if (sv_we) begin
        sv_valid[sv_waddr] <= 1'b1;
      end
      if (mac_done && row3 == LAST_ROW) begin
        bank <= !bank;
      end
    end
  end

  // Capture outputs as their rows finish
  always_ff @(posedge clk) begin
    if (mac_done && row3 == '0) begin
      y0 <= mac_res;
      if (NUM_OUTPUTS == 1) begin
        y1 <= '0;
      end
    end
    if (NUM_OUTPUTS > 1 && mac_done && row3 == RW'(1)) begin
      y1 <= mac_res;
    end
  end

  // Result valid: set on the last output row, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (mac_done && row3 == LAST_OUT) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {y1, y0};

endmodule

FILE: sv/dss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dss_mac.sv
// Shared multiply-accumulate unit: 32x32 product, arithmetic shift, wide row sum,
// saturation to 32 bits. Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_mac #(
  parameter int FRAC_BITS = 16,
  parameter int TERMS     = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dss_pkg::mac_tag_t                  tag,
  input  logic signed [dss_pkg::DATA_W-1:0]  a,
  input  logic signed [dss_pkg::DATA_W-1:0]  b,
  output logic                               done,
  output logic signed [dss_pkg::DATA_W-1:0]  result
);

  localparam int ACC_W = 2 * dss_pkg::DATA_W - FRAC_BITS + $clog2(TERMS) + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  dss_pkg::mac_tag_t                       tag_p;
  logic signed [2*dss_pkg::DATA_W-1:0]     prod;
  logic signed [2*dss_pkg::DATA_W-1:0]     shifted;
  logic signed [ACC_W-1:0]                 term;
  logic signed [ACC_W-1:0]                 acc;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p <= '0;
    end else begin
      tag_p <= tag;
    end
    prod <= (2*dss_pkg::DATA_W)'(a) * (2*dss_pkg::DATA_W)'(b);
  end

  // Floor-rounded scaling of the product
  assign shifted = prod >>> FRAC_BITS;
  assign term    = ACC_W'(shifted);

  // Accumulate stage: restart on the first term of a row
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_p.valid && tag_p.last;
    end
    if (tag_p.valid) begin
      acc <= tag_p.first ? term : acc + term;
    end
  end

  // Saturate the finished row sum
  always_comb begin
    if (acc > SAT_HI) begin
      result = 32'sh7fffffff;
    end else if (acc < SAT_LO) begin
      result = 32'sh80000000;
    end else begin
      result = signed'(acc[dss_pkg::DATA_W-1:0]);
    end
  end

endmodule

FILE: sv/dss_chk.sv
// Port-level checker for the discrete state-space step, bound to the top level.
// Depends on dss_pkg and discrete_state_space_step.
`timescale 1ns / 1ps

module dss_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [0:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dss_pkg::M_TDATA_W-1:0] m_tdata
);

  // A stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A sample transfer makes the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("input taken right after a sample");

  // No sample is taken while an earlier result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(s_tvalid && s_tready && s_tuser[0]))
    else $error("sample taken over a stalled result");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind discrete_state_space_step dss_chk u_dss_chk (.*);

FILE: bench/discrete_state_space_step_test.sv
// Self-checking bench for discrete_state_space_step: streams coefficient loads and
// input samples, predicts y = Cx + Du and x' = Ax + Bu in fixed point, checks outputs.
// Depends on dss_pkg and the discrete_state_space_step RTL.
`timescale 1ns / 1ps

module discrete_state_space_step_test;

  localparam int NUM_STATES  = 4;
  localparam int NUM_INPUTS  = 2;
  localparam int NUM_OUTPUTS = 2;
  localparam int FRAC_BITS   = 16;

  // Flat address map of the load space
  localparam int OFS_A      = 0;
  localparam int OFS_B      = OFS_A + NUM_STATES * NUM_STATES;
  localparam int OFS_C      = OFS_B + NUM_STATES * NUM_INPUTS;
  localparam int OFS_D      = OFS_C + NUM_OUTPUTS * NUM_STATES;
  localparam int OFS_X      = OFS_D + NUM_OUTPUTS * NUM_INPUTS;
  localparam int ADDR_END   = OFS_X + NUM_STATES;
  localparam int RANDOM_ITEMS = 840;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef struct packed {
    logic [31:0] y1;
    logic [31:0] y0;
  } y_pair_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [dss_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0]                    s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [dss_pkg::M_TDATA_W-1:0] m_tdata;

  // Predicted system: coefficients and state vector (state starts at zero)
  logic signed [31:0] coeff_words [OFS_X];
  logic signed [31:0] x_state [NUM_STATES] = '{default: '0};

  y_pair_t y_expected [$];
  bit      quiet = 1'b0;
  int      error_count = 0;
  int      n_samples = 0;
  int      n_loads = 0;
  int      n_ignored = 0;
  int      n_saturated = 0;
  int      n_checked = 0;

  discrete_state_space_step #(
    .NUM_STATES (NUM_STATES),
    .NUM_INPUTS (NUM_INPUTS),
    .NUM_OUTPUTS(NUM_OUTPUTS),
    .FRAC_BITS  (FRAC_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact product, floor-shifted back to the fixed-point scale
  function automatic longint scaled_product(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  // Output from the old state, then advance the state; every term uses the old x
  task automatic advance_system(input logic signed [31:0] u0, input logic signed [31:0] u1,
                                output y_pair_t y);
    logic signed [31:0] u [NUM_INPUTS];
    logic signed [31:0] y_row [NUM_OUTPUTS];
    logic signed [31:0] x_next [NUM_STATES];
    longint acc;
    u[0] = u0;
    u[1] = u1;
    for (int i = 0; i < NUM_OUTPUTS; i++) begin
      acc = 0;
      for (int j = 0; j < NUM_STATES; j++)
        acc += scaled_product(coeff_words[OFS_C + i * NUM_STATES + j], x_state[j]);
      for (int j = 0; j < NUM_INPUTS; j++)
        acc += scaled_product(coeff_words[OFS_D + i * NUM_INPUTS + j], u[j]);
      if (acc > longint'(Q_MAX) || acc < longint'(Q_MIN)) n_saturated++;
      y_row[i] = clamp32(acc);
    end
    for (int i = 0; i < NUM_STATES; i++) begin
      acc = 0;
      for (int j = 0; j < NUM_STATES; j++)
        acc += scaled_product(coeff_words[OFS_A + i * NUM_STATES + j], x_state[j]);
      for (int j = 0; j < NUM_INPUTS; j++)
        acc += scaled_product(coeff_words[OFS_B + i * NUM_INPUTS + j], u[j]);
      x_next[i] = clamp32(acc);
    end
    x_state = x_next;
    y.y0 = y_row[0];
    y.y1 = y_row[1];
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Word mix: small Q16.16 values keep the state alive, some extremes and full range
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return int'($urandom_range(0, 262144)) - 131072;
    if (r < 7) return int'($urandom_range(0, 65536)) - 32768;
    if (r < 8) begin
      case ($urandom_range(0, 4))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return 32'h0;
        3: return 32'hFFFF_FFFF;
        default: return 32'h1;
      endcase
    end
    return $urandom();
  endfunction

  // Present one item, hold it until the transfer, then update the prediction
  task automatic send_item(input func_t fn, input logic [5:0] addr, input logic [31:0] value,
                           input logic [31:0] u0, input logic [31:0] u1);
    y_pair_t y;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {2'b00, u1, u0, value, addr};
    do @(posedge clk); while (!s_tready);
    if (fn == FUNC_LOAD) begin
      n_loads++;
      if (addr < OFS_X) coeff_words[addr] = value;
      else if (addr < ADDR_END) x_state[addr - OFS_X] = value;
      else n_ignored++;
    end else begin
      n_samples++;
      advance_system(u0, u1, y);
      y_expected.push_back(y);
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic fill_words(input int base, input int count, input logic [31:0] value);
    for (int k = 0; k < count; k++)
      send_item(FUNC_LOAD, 6'(base + k), value, $urandom(), $urandom());
  endtask

  // Idle the sender and wait for every pending result
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (y_expected.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls, long and short; no new stall starts while quiet
  always @(posedge clk) begin
    int hold;
    if (hold > 0) begin
      hold--;
    end else if (quiet || $urandom_range(0, 1)) begin
      m_tready <= 1'b1;
      hold = $urandom_range(1, 8);
    end else begin
      m_tready <= 1'b0;
      hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    y_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (y_expected.size() == 0) begin
        $display("%0t: output with none pending: got %h", $time, m_tdata);
        error_count++;
      end else begin
        want = y_expected.pop_front();
        n_checked++;
        if (m_tdata[31:0] !== want.y0) begin
          $display("%0t: y0 expected %h actual %h", $time, want.y0, m_tdata[31:0]);
          error_count++;
        end
        if (m_tdata[63:32] !== want.y1) begin
          $display("%0t: y1 expected %h actual %h", $time, want.y1, m_tdata[63:32]);
          error_count++;
        end
      end
    end
  end

  // Write every coefficient and state word so no sample reads an unwritten word
  task automatic test_load_matrices();
    for (int a = 0; a < OFS_X; a++)
      send_item(FUNC_LOAD, 6'(a), int'($urandom_range(0, 131072)) - 65536,
                $urandom(), $urandom());
    send_item(FUNC_LOAD, 6'(OFS_X + 0), Q_MAX, 32'h0, 32'h0);
    send_item(FUNC_LOAD, 6'(OFS_X + 1), Q_MIN, 32'h0, 32'h0);
    send_item(FUNC_LOAD, 6'(OFS_X + 2), 32'h0, 32'h0, 32'h0);
    send_item(FUNC_LOAD, 6'(OFS_X + 3), 32'hFFFF_FFFF, 32'h0, 32'h0);
  endtask

  // Input extremes, ignored fields, loads past the end, saturation and floor rounding
  task automatic test_edge_samples();
    send_item(FUNC_SAMPLE, 6'h3F, 32'hFFFF_FFFF, Q_MAX, Q_MIN);
    send_item(FUNC_SAMPLE, 6'h00, 32'h0, 32'h0, 32'h0);
    send_item(FUNC_SAMPLE, 6'h15, $urandom(), 32'hFFFF_FFFF, 32'h1);
    send_item(FUNC_LOAD, 6'(ADDR_END), $urandom(), Q_MAX, Q_MAX);
    send_item(FUNC_LOAD, 6'h3F, $urandom(), Q_MIN, Q_MIN);
    send_item(FUNC_SAMPLE, 6'h00, 32'h0, Q_MIN, Q_MIN);
    // drive outputs hard into both rails
    fill_words(OFS_C, OFS_X - OFS_C, Q_MAX);
    fill_words(OFS_X, NUM_STATES, Q_MAX);
    send_item(FUNC_SAMPLE, 6'h00, 32'h0, Q_MAX, Q_MAX);
    fill_words(OFS_C, OFS_X - OFS_C, Q_MIN);
    send_item(FUNC_SAMPLE, 6'h00, 32'h0, Q_MAX, Q_MAX);
    // smallest negative product must round down to minus one LSB
    fill_words(OFS_C, OFS_X - OFS_C, 32'h0);
    send_item(FUNC_LOAD, 6'(OFS_C), 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_item(FUNC_LOAD, 6'(OFS_X), 32'h1, 32'h0, 32'h0);
    send_item(FUNC_SAMPLE, 6'h00, 32'h0, 32'h0, 32'h0);
    send_item(FUNC_LOAD, 6'(OFS_D + 1), Q_ONE, 32'h0, 32'h0);
    send_item(FUNC_SAMPLE, 6'h00, 32'h0, 32'h1, 32'hFFFF_FFFF);
  endtask

  // Hold the sender until the output side has fully caught up
  task automatic test_drain_pause();
    for (int k = 0; k < 4; k++)
      send_item(FUNC_SAMPLE, 6'($urandom()), $urandom(), pick_word(), pick_word());
    wait_results_drained();
    send_item(FUNC_SAMPLE, 6'($urandom()), $urandom(), pick_word(), pick_word());
  endtask

  // Bursts of loads followed by runs of samples, with noise items mixed in
  task automatic test_random_mix();
    int counted;
    int n_load;
    int n_run;
    logic [5:0] addr;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet = (counted >= 300 && counted < 380);
      if ($urandom_range(0, 9) < 8) begin
        n_load = $urandom_range(0, 4);
        n_run  = $urandom_range(2, 8);
        for (int k = 0; k < n_load; k++) begin
          addr = 6'($urandom_range(0, ADDR_END - 1));
          send_item(FUNC_LOAD, addr, pick_word(), $urandom(), $urandom());
          counted++;
        end
        for (int k = 0; k < n_run; k++) begin
          send_item(FUNC_SAMPLE, 6'($urandom()), $urandom(), pick_word(), pick_word());
          counted++;
        end
      end else begin
        addr = 6'($urandom());
        send_item(FUNC_LOAD, addr, $urandom(), $urandom(), $urandom());
        if (addr < ADDR_END) counted++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_matrices();
    test_edge_samples();
    test_drain_pause();
    test_random_mix();
    s_tvalid <= 1'b0;
    wait_results_drained();
    repeat (60) @(posedge clk);
    $display("Covered %0d samples (%0d checked, %0d saturated sums), %0d loads, %0d past the end",
             n_samples, n_checked, n_saturated, n_loads, n_ignored);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #8_000_000;
    $display("Timeout with %0d outputs pending", y_expected.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
